// File: design/srf_pkg.sv
// Package for the RRIP replacement block with spatial filter.
// Holds beat types, register codes, defaults and state machine type.
// No dependencies.
`default_nettype none
package srf_pkg;

   // default sizing of the block
   localparam int NUM_SETS_DEF          = 2048;
   localparam int NUM_WAYS_DEF          = 16;
   localparam int FILTER_DEPTH_DEF      = 8;
   localparam int RRIP_WIDTH_DEF        = 2;
   localparam int BLOCK_OFFSET_BITS_DEF = 6;

   // fixed field widths
   localparam int SET_IN_W = 11;
   localparam int WAY_IN_W = 4;
   localparam int ADDR_W   = 64;
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPATIAL_THRESH   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_SPATIAL   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_IRREGULAR = 4'd3;

   localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST    = 7'd64;
   localparam logic [CNT_W-1:0] SPATIAL_THRESH_RST   = 7'd38;
   localparam logic [VAL_W-1:0] INSERT_SPATIAL_RST   = 2'd1;
   localparam logic [VAL_W-1:0] INSERT_IRREGULAR_RST = 2'd3;

   localparam logic MODE_VICTIM = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [SET_IN_W-1:0] set_index;
      logic [WAY_IN_W-1:0] way_index;
      logic [ADDR_W-1:0]   physical_address;
      logic                was_hit;
   } req_type;

   typedef struct packed {
      logic [WAY_IN_W-1:0] victim_way;
      logic [VAL_W-1:0]    new_rrip;
      logic                set_is_spatial;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] window_length;
      logic [CNT_W-1:0] spatial_count_threshold;
      logic [VAL_W-1:0] insert_spatial;
      logic [VAL_W-1:0] insert_irregular;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

// File: design/srf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module srf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: design/srf_datapath.sv
// Per-set compute: victim aging and search, filter match, window stats,
// FIFO push and new re-reference value. Uses srf_pkg.
`default_nettype none
module srf_datapath #(
   parameter int NUM_WAYS          = srf_pkg::NUM_WAYS_DEF,
   parameter int FILTER_DEPTH      = srf_pkg::FILTER_DEPTH_DEF,
   parameter int RRIP_WIDTH        = srf_pkg::RRIP_WIDTH_DEF,
   parameter int BLOCK_OFFSET_BITS = srf_pkg::BLOCK_OFFSET_BITS_DEF,
   localparam int BLK_W  = srf_pkg::ADDR_W - BLOCK_OFFSET_BITS,
   localparam int FILL_W = $clog2(FILTER_DEPTH + 1),
   localparam int HEAD_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1,
   localparam int CW     = srf_pkg::CNT_W,
   localparam int META_W = 2 * CW + 1 + FILL_W + HEAD_W
) (
   input  wire srf_pkg::cfg_type                            cfg,
   input  wire logic                                        mode,
   input  wire logic [srf_pkg::WAY_IN_W-1:0]                way_in,
   input  wire logic [BLK_W-1:0]                            blk,
   input  wire logic                                        was_hit,
   input  wire logic [NUM_WAYS-1:0][RRIP_WIDTH-1:0]         rrip_rd,
   input  wire logic [META_W-1:0]                           meta_rd,
   input  wire logic [FILTER_DEPTH-1:0][BLK_W-1:0]          blk_rd,
   output logic                                             rrip_we,
   output logic      [NUM_WAYS-1:0][RRIP_WIDTH-1:0]         rrip_wr,
   output logic                                             meta_we,
   output logic      [META_W-1:0]                           meta_wr,
   output logic                                             blk_we,
   output logic      [FILTER_DEPTH-1:0][BLK_W-1:0]          blk_wr,
   output srf_pkg::rsp_type                                 rsp
);
   localparam int SUM_W  = FILL_W + 1;
   localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   localparam logic [RRIP_WIDTH-1:0] RMAX = '1;

   logic [CW-1:0]     acc, hits, acc1, hits1;
   logic              spatial, spatial1;
   logic [FILL_W-1:0] fill, fill1;
   logic [HEAD_W-1:0] head, head1, slot;
   logic [SUM_W-1:0]  sum, hinc;

   logic [RRIP_WIDTH-1:0]                top, add;
   logic [NUM_WAYS-1:0][RRIP_WIDTH-1:0]  aged;
   logic [WAY_W-1:0]                     vic;
   logic                                 found;

   logic       nb, frequent, way_ok;
   logic [1:0] v2;
   logic [3:0] v4;
   logic [RRIP_WIDTH-1:0] vclamp;
   logic [BLK_W-1:0] e_up, e_dn;

   assign {acc, hits, spatial, fill, head} = meta_rd;

   // victim: age to the max and take the lowest way at max
   always_comb begin
      top   = '0;
      found = 1'b0;
      vic   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (rrip_rd[w] > top) top = rrip_rd[w];
      end
      add = RMAX - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = rrip_rd[w] + add;
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found && aged[w] == RMAX) begin
            vic   = WAY_W'(w);
            found = 1'b1;
         end
      end
   end

   // filter match over the filled slots, all compared in parallel
   always_comb begin
      nb       = 1'b0;
      frequent = 1'b0;
      e_up     = '0;
      e_dn     = '0;
      for (int i = 0; i < FILTER_DEPTH; i++) begin
         e_up = blk_rd[i] + BLK_W'(1);
         e_dn = blk_rd[i] - BLK_W'(1);
         if (SUM_W'(i) < SUM_W'(fill)) begin
            if (blk == e_up || blk == e_dn) nb = 1'b1;
            if (blk == blk_rd[i]) frequent = 1'b1;
         end
      end
   end

   // window statistics and classification
   always_comb begin
      acc1     = (acc < srf_pkg::CNT_MAX) ? acc + CW'(1) : acc;
      hits1    = (nb && hits < srf_pkg::CNT_MAX) ? hits + CW'(1) : hits;
      spatial1 = spatial;
      if (acc1 >= cfg.window_length) begin
         spatial1 = hits1 > cfg.spatial_count_threshold;
         acc1     = '0;
         hits1    = '0;
      end
   end

   // FIFO push of a block not already held: append while not full, else overwrite oldest
   always_comb begin
      sum = SUM_W'(head) + SUM_W'(fill);
      if (sum >= SUM_W'(FILTER_DEPTH)) sum = sum - SUM_W'(FILTER_DEPTH);
      hinc = SUM_W'(head) + SUM_W'(1);
      if (hinc >= SUM_W'(FILTER_DEPTH)) hinc = '0;
      fill1  = fill;
      head1  = head;
      blk_wr = blk_rd;
      if (SUM_W'(fill) < SUM_W'(FILTER_DEPTH)) begin
         slot  = sum[HEAD_W-1:0];
         fill1 = fill + FILL_W'(1);
      end else begin
         slot  = head;
         head1 = hinc[HEAD_W-1:0];
      end
      if (!frequent) begin
         blk_wr[slot] = blk;
      end else begin
         fill1 = fill;
         head1 = head;
      end
   end

   // new re-reference value
   always_comb begin
      if (was_hit)       v2 = frequent ? 2'd0 : 2'd1;
      else if (spatial1) v2 = frequent ? 2'd0 : cfg.insert_spatial;
      else               v2 = frequent ? 2'd1 : cfg.insert_irregular;
      v4     = 4'(v2);
      vclamp = (v4 > 4'(RMAX)) ? RMAX : RRIP_WIDTH'(v2);
      way_ok = {2'b00, way_in} < 6'(NUM_WAYS);
   end

   // write-back and response
   always_comb begin
      meta_wr = {acc1, hits1, spatial1, fill1, head1};
      rrip_wr = rrip_rd;
      rsp     = '0;
      if (mode == srf_pkg::MODE_VICTIM) begin
         rrip_wr            = aged;
         rrip_we            = 1'b1;
         meta_we            = 1'b0;
         blk_we             = 1'b0;
         rsp.victim_way     = srf_pkg::WAY_IN_W'(vic);
         rsp.set_is_spatial = spatial;
      end else begin
         rrip_wr[WAY_W'(way_in)] = vclamp;
         rrip_we            = way_ok;
         meta_we            = 1'b1;
         blk_we             = !frequent;
         rsp.new_rrip       = srf_pkg::VAL_W'(vclamp);
         rsp.set_is_spatial = spatial1;
      end
   end
endmodule
`default_nettype wire

// File: design/rrip_spatial_filter_replacement.sv
// RRIP replacement with per-set spatial filter: one item at a time.
// Memories are read at the accepting edge; the execute state computes and
// writes back and loads the registered result. A new item waits for idle.
// After reset a clearing pass over all NUM_SETS sets initializes the line and
// set memories; busy stays high during it. The result receiver cannot stall.
// Depends on srf_pkg, srf_ram, srf_datapath.
`default_nettype none
module rrip_spatial_filter_replacement #(
   parameter int NUM_SETS          = srf_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS          = srf_pkg::NUM_WAYS_DEF,
   parameter int FILTER_DEPTH      = srf_pkg::FILTER_DEPTH_DEF,
   parameter int RRIP_WIDTH        = srf_pkg::RRIP_WIDTH_DEF,
   parameter int BLOCK_OFFSET_BITS = srf_pkg::BLOCK_OFFSET_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire srf_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   output srf_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [srf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [srf_pkg::CSR_DATA_W-1:0]     csr_data
);
   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int BLK_W  = srf_pkg::ADDR_W - BLOCK_OFFSET_BITS;
   localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
   localparam int HEAD_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int META_W = 2 * srf_pkg::CNT_W + 1 + FILL_W + HEAD_W;
   localparam int ROW_W  = NUM_WAYS * RRIP_WIDTH;
   localparam int FROW_W = FILTER_DEPTH * BLK_W;

   // reset word of a set: counters zero, spatial, filter empty
   localparam logic [META_W-1:0] META_CLR = META_W'(1) << (FILL_W + HEAD_W);

   srf_pkg::state_type state_ff, state_in;
   srf_pkg::cfg_type   cfg_ff;
   logic [SET_W-1:0]   clr_ff, clr_in;
   logic [SET_W-1:0]   set_ff, set_red;
   logic               mode_ff, hit_ff;
   logic [srf_pkg::WAY_IN_W-1:0] way_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   srf_pkg::rsp_type   rsp_ff, rsp_calc;
   logic               accept;

   logic [ROW_W-1:0]   rrip_rd, rrip_wr, rrip_wdata;
   logic [META_W-1:0]  meta_rd, meta_wr, meta_wdata;
   logic [FROW_W-1:0]  blk_rd, blk_wr;
   logic               rrip_we, meta_we, blk_we;
   logic [SET_W-1:0]   wr_addr;
   logic               exec;
   logic [31:0]        rem;

   assign accept    = start && !busy;
   assign busy      = reset || state_ff != srf_pkg::ST_IDLE;
   assign csr_ready = 1'b1;
   assign exec      = state_ff == srf_pkg::ST_EXEC;

   // set index reduced modulo NUM_SETS by restoring subtraction
   always_comb begin
      rem = 32'(req_data.set_index);
      for (int k = srf_pkg::SET_IN_W - 1; k >= 0; k--) begin
         if (rem >= (32'(NUM_SETS) << k)) rem = rem - (32'(NUM_SETS) << k);
      end
      set_red = rem[SET_W-1:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length           <= srf_pkg::WINDOW_LENGTH_RST;
         cfg_ff.spatial_count_threshold <= srf_pkg::SPATIAL_THRESH_RST;
         cfg_ff.insert_spatial          <= srf_pkg::INSERT_SPATIAL_RST;
         cfg_ff.insert_irregular        <= srf_pkg::INSERT_IRREGULAR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srf_pkg::CSR_WINDOW_LENGTH: cfg_ff.window_length <= csr_data;
            srf_pkg::CSR_SPATIAL_THRESH: cfg_ff.spatial_count_threshold <= csr_data;
            srf_pkg::CSR_INSERT_SPATIAL:
               cfg_ff.insert_spatial <= srf_pkg::VAL_W'(csr_data);
            srf_pkg::CSR_INSERT_IRREGULAR:
               cfg_ff.insert_irregular <= srf_pkg::VAL_W'(csr_data);
            default: ;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         srf_pkg::ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (32'(clr_ff) == 32'(NUM_SETS - 1)) state_in = srf_pkg::ST_IDLE;
         end
         srf_pkg::ST_IDLE: begin
            if (start) state_in = srf_pkg::ST_EXEC;
         end
         srf_pkg::ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = srf_pkg::ST_IDLE;
         end
         default: state_in = srf_pkg::ST_IDLE;
      endcase
   end

   // item and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff  <= set_red;
         mode_ff <= req_data.mode;
         way_ff  <= req_data.way_index;
         blk_ff  <= BLK_W'(req_data.physical_address >> BLOCK_OFFSET_BITS);
         hit_ff  <= req_data.was_hit;
      end
      if (exec) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // write port: clearing pass or write-back
   always_comb begin
      wr_addr    = exec ? set_ff : clr_ff;
      rrip_wdata = exec ? rrip_wr : '1;
      meta_wdata = exec ? meta_wr : META_CLR;
   end

   srf_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrip_ram (
      .clock   (clock),
      .wr_en   ((exec && rrip_we) || state_ff == srf_pkg::ST_CLEAR),
      .wr_addr (wr_addr),
      .wr_data (rrip_wdata),
      .rd_en   (accept),
      .rd_addr (set_red),
      .rd_data (rrip_rd)
   );

   srf_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   ((exec && meta_we) || state_ff == srf_pkg::ST_CLEAR),
      .wr_addr (wr_addr),
      .wr_data (meta_wdata),
      .rd_en   (accept),
      .rd_addr (set_red),
      .rd_data (meta_rd)
   );

   srf_ram #(.WIDTH(FROW_W), .DEPTH(NUM_SETS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (exec && blk_we),
      .wr_addr (set_ff),
      .wr_data (blk_wr),
      .rd_en   (accept),
      .rd_addr (set_red),
      .rd_data (blk_rd)
   );

   srf_datapath #(
      .NUM_WAYS          (NUM_WAYS),
      .FILTER_DEPTH      (FILTER_DEPTH),
      .RRIP_WIDTH        (RRIP_WIDTH),
      .BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS)
   ) u_dp (
      .cfg     (cfg_ff),
      .mode    (mode_ff),
      .way_in  (way_ff),
      .blk     (blk_ff),
      .was_hit (hit_ff),
      .rrip_rd (rrip_rd),
      .meta_rd (meta_rd),
      .blk_rd  (blk_rd),
      .rrip_we (rrip_we),
      .rrip_wr (rrip_wr),
      .meta_we (meta_we),
      .meta_wr (meta_wr),
      .blk_we  (blk_we),
      .blk_wr  (blk_wr),
      .rsp     (rsp_calc)
   );
endmodule
`default_nettype wire

// File: design/srf_checker.sv
// Port-level checks for rrip_spatial_filter_replacement, bound to the top.
// Depends on srf_pkg.
`default_nettype none
module srf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire srf_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire srf_pkg::rsp_type rsp_data
);
   // an accepted beat makes the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   // every result answers a beat accepted before the execute state that produced it
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 2))
      else $error("result without an accepted beat");

   // one beat, one result
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      $past(!reset, 2) && $past(start && !busy, 2) |-> rsp_valid)
      else $error("accepted beat lost its result");

   // victim requests report no re-reference value
   a_victim_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.mode == srf_pkg::MODE_VICTIM, 2)
      |-> rsp_data.new_rrip == '0) else $error("victim result with value");
endmodule

bind rrip_spatial_filter_replacement srf_checker u_srf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
